// ----- hw/rtl/pgf_pkg.sv -----
// Shared widths, pipeline record types and helpers for the pairwise gravity force block.
package pgf_pkg;

	// Position fields are taken from their low POS_W bits and sign-extended.
	localparam int COORD_WIDTH = 32;
	localparam int POS_W       = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam int DIFF_W      = 33;

	localparam logic [31:0] GRAV_RESET = 32'd4294967;

	// Square root: 98-bit radicand, two bits per stage, 49-bit root.
	localparam int SQ_N   = 49;
	localparam int RAD_W  = 2 * SQ_N;
	localparam int SREM_W = 52;

	// Division: 32 quotient bits, one per stage.
	localparam int DV_N  = 32;
	localparam int NUM_W = 128;
	localparam int DEN_W = 117;

	localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] LIM_NEG = 32'h8000_0000;

	// Values that ride along with the square root stages.
	typedef struct packed {
		logic              neg_x;
		logic              neg_y;
		logic              zero;
		logic [DIFF_W-1:0] mag_x;
		logic [DIFF_W-1:0] mag_y;
		logic [33:0]       thr;
		logic [95:0]       base;
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [SQ_N-1:0]   root;
	} sq_t;

	// Values that ride along with the divider stages.
	typedef struct packed {
		logic             neg_x;
		logic             neg_y;
		logic             zero;
		logic             clamp;
		logic             sat_x;
		logic             sat_y;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem_x;
		logic [DEN_W-1:0] rem_y;
		logic [31:0]      lo_x;
		logic [31:0]      lo_y;
		logic [31:0]      q_x;
		logic [31:0]      q_y;
	} dv_t;

	// Sign-extend a position from its low POS_W bits.
	function automatic logic signed [DIFF_W-1:0] pos_ext(input logic [31:0] v);
		logic signed [POS_W-1:0] t;
		t = v[POS_W-1:0];
		return DIFF_W'(t);
	endfunction

endpackage

// ----- hw/rtl/pairwise_gravity_force.sv -----
// Top level of the pairwise gravity force pipeline.
//
// Usage: one transaction on the s_t* channel carries a body pair; one transaction
// on the m_t* channel returns the 2D force on the first body (the second body gets
// the negated force) and a flag in m_tuser that is set when the distance was
// raised to three times the larger radius. G is written over the cfg_* channel,
// which is always ready; write it only while no pair is in flight.
// Throughput is one pair per cycle unless the receiver stalls; there are three input
// stages, 49 square root stages (two radicand bits each), five multiply and compare
// stages, 32 divider stages (one quotient bit each) and the output register.
// Reset clears all valid bits and loads G with its default of about 0.001.
// When the receiver holds m_tready low with a result waiting, the whole pipeline
// freezes and s_tready drops; nothing is lost or repeated.
module pairwise_gravity_force (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b, radius_a, radius_b
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y
	output logic [63:0]  m_tdata,
	// distance_clamped
	output logic [0:0]   m_tuser
);
	import pgf_pkg::*;

	logic en;
	logic [31:0] grav_q;

	// Gravitational constant register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAV_RESET;
		end else if (cfg_valid) begin
			grav_q <= cfg_data;
		end
	end

	// The whole pipeline moves unless a result waits on a stalled receiver.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: differences, magnitudes, threshold and G*mass_a.
	logic signed [DIFF_W-1:0] pa_x, pa_y, pb_x, pb_y, dx, dy;
	logic [31:0] rmax;
	logic v_s1;
	logic neg_x_s1, neg_y_s1, zero_s1;
	logic [DIFF_W-1:0] mag_x_s1, mag_y_s1;
	logic [33:0] thr_s1;
	logic [63:0] gm_s1;
	logic [31:0] mb_s1;

	always_comb begin
		pa_x = pos_ext(s_tdata[31:0]);
		pa_y = pos_ext(s_tdata[63:32]);
		pb_x = pos_ext(s_tdata[95:64]);
		pb_y = pos_ext(s_tdata[127:96]);
		dx   = pb_x - pa_x;
		dy   = pb_y - pa_y;
		rmax = (s_tdata[223:192] > s_tdata[255:224]) ? s_tdata[223:192] : s_tdata[255:224];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s1 <= dx[DIFF_W-1];
			neg_y_s1 <= dy[DIFF_W-1];
			zero_s1  <= (dx == '0) && (dy == '0);
			mag_x_s1 <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
			mag_y_s1 <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
			thr_s1   <= {2'b00, rmax} + {1'b0, rmax, 1'b0};
			gm_s1    <= 64'(grav_q) * 64'(s_tdata[159:128]);
			mb_s1    <= s_tdata[191:160];
		end
	end

	// Stage 2: squares of the differences and the two halves of G*ma*mb.
	logic v_s2;
	logic neg_x_s2, neg_y_s2, zero_s2;
	logic [DIFF_W-1:0] mag_x_s2, mag_y_s2;
	logic [33:0] thr_s2;
	logic [65:0] sx_s2, sy_s2;
	logic [63:0] pb0_s2, pb1_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			zero_s2  <= zero_s1;
			mag_x_s2 <= mag_x_s1;
			mag_y_s2 <= mag_y_s1;
			thr_s2   <= thr_s1;
			sx_s2    <= 66'(mag_x_s1) * 66'(mag_x_s1);
			sy_s2    <= 66'(mag_y_s1) * 66'(mag_y_s1);
			pb0_s2   <= 64'(gm_s1[31:0]) * 64'(mb_s1);
			pb1_s2   <= 64'(gm_s1[63:32]) * 64'(mb_s1);
		end
	end

	// Stage 3: squared distance in Q34.64 and the full G*ma*mb product.
	logic v_s3;
	sq_t sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.neg_x <= neg_x_s2;
			sq_s3.neg_y <= neg_y_s2;
			sq_s3.zero  <= zero_s2;
			sq_s3.mag_x <= mag_x_s2;
			sq_s3.mag_y <= mag_y_s2;
			sq_s3.thr   <= thr_s2;
			sq_s3.base  <= {32'd0, pb0_s2} + {pb1_s2, 32'd0};
			sq_s3.rad   <= {sx_s2 + sy_s2, 32'd0};
			sq_s3.rem   <= '0;
			sq_s3.root  <= '0;
		end
	end

	// Square root pipeline: each stage settles one root bit.
	sq_t  sq_s [SQ_N];
	logic sq_v [SQ_N];

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		sq_t sin, sout;
		logic vin;
		logic [SREM_W-1:0] cur, trial;
		logic ge;

		if (k == 0) begin : g_first
			assign sin = sq_s3;
			assign vin = v_s3;
		end else begin : g_next
			assign sin = sq_s[k-1];
			assign vin = sq_v[k-1];
		end

		always_comb begin
			cur   = {sin.rem[SREM_W-3:0], sin.rad[RAD_W-1:RAD_W-2]};
			trial = {1'b0, sin.root, 2'b01};
			ge    = cur >= trial;
			sout      = sin;
			sout.rem  = ge ? (cur - trial) : cur;
			sout.root = {sin.root[SQ_N-2:0], ge};
			sout.rad  = {sin.rad[RAD_W-3:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else if (en) begin
				sq_v[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k] <= sout;
			end
		end
	end

	// Stage A: clamp the distance against three times the larger radius.
	sq_t sq_last;
	logic [32:0] r_a;
	logic v_sa, clamp_sa;
	logic neg_x_sa, neg_y_sa, zero_sa;
	logic [DIFF_W-1:0] mag_x_sa, mag_y_sa;
	logic [95:0] base_sa;
	logic [SQ_N-1:0] rf_sa;
	logic [33:0] rc_sa;

	assign sq_last = sq_s[SQ_N-1];
	assign r_a     = sq_last.root[SQ_N-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_sa <= sq_last.neg_x;
			neg_y_sa <= sq_last.neg_y;
			zero_sa  <= sq_last.zero;
			mag_x_sa <= sq_last.mag_x;
			mag_y_sa <= sq_last.mag_y;
			base_sa  <= sq_last.base;
			rf_sa    <= sq_last.root;
			clamp_sa <= {1'b0, r_a} < sq_last.thr;
			rc_sa    <= ({1'b0, r_a} < sq_last.thr) ? sq_last.thr : {1'b0, r_a};
		end
	end

	// Stage B: rc squared and the partial products of the numerators.
	logic v_sb, clamp_sb;
	logic neg_x_sb, neg_y_sb, zero_sb;
	logic [SQ_N-1:0] rf_sb;
	logic [67:0] rc2_sb;
	logic [64:0] px_sb [3];
	logic [64:0] py_sb [3];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_sb <= neg_x_sa;
			neg_y_sb <= neg_y_sa;
			zero_sb  <= zero_sa;
			clamp_sb <= clamp_sa;
			rf_sb    <= rf_sa;
			rc2_sb   <= 68'(rc_sa) * 68'(rc_sa);
			for (int i = 0; i < 3; i++) begin
				px_sb[i] <= 65'(base_sa[32*i +: 32]) * 65'(mag_x_sa);
				py_sb[i] <= 65'(base_sa[32*i +: 32]) * 65'(mag_y_sa);
			end
		end
	end

	// Stage C: numerator sums and the partial products of rc^2 * rf.
	logic v_sc, clamp_sc;
	logic neg_x_sc, neg_y_sc, zero_sc;
	logic [NUM_W-1:0] num_x_sc, num_y_sc;
	logic [58:0] d00_sc, d10_sc;
	logic [57:0] d01_sc, d11_sc;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_sc <= neg_x_sb;
			neg_y_sc <= neg_y_sb;
			zero_sc  <= zero_sb;
			clamp_sc <= clamp_sb;
			num_x_sc <= NUM_W'(px_sb[0]) + (NUM_W'(px_sb[1]) << 32) + (NUM_W'(px_sb[2]) << 64);
			num_y_sc <= NUM_W'(py_sb[0]) + (NUM_W'(py_sb[1]) << 32) + (NUM_W'(py_sb[2]) << 64);
			d00_sc   <= 59'(rc2_sb[33:0]) * 59'(rf_sb[24:0]);
			d10_sc   <= 59'(rc2_sb[67:34]) * 59'(rf_sb[24:0]);
			d01_sc   <= 58'(rc2_sb[33:0]) * 58'(rf_sb[48:25]);
			d11_sc   <= 58'(rc2_sb[67:34]) * 58'(rf_sb[48:25]);
		end
	end

	// Stage D: full denominator rc^2 * rf.
	logic v_sd, clamp_sd;
	logic neg_x_sd, neg_y_sd, zero_sd;
	logic [NUM_W-1:0] num_x_sd, num_y_sd;
	logic [DEN_W-1:0] den_sd;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_sd <= neg_x_sc;
			neg_y_sd <= neg_y_sc;
			zero_sd  <= zero_sc;
			clamp_sd <= clamp_sc;
			num_x_sd <= num_x_sc;
			num_y_sd <= num_y_sc;
			den_sd   <= DEN_W'(d00_sc) + (DEN_W'(d01_sc) << 25) + (DEN_W'(d10_sc) << 34)
			          + (DEN_W'(d11_sc) << 59);
		end
	end

	// Stage E: a quotient of 2^32 or more saturates; otherwise seed the divider.
	logic v_se;
	dv_t dv_se;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_se.neg_x <= neg_x_sd;
			dv_se.neg_y <= neg_y_sd;
			dv_se.zero  <= zero_sd;
			dv_se.clamp <= clamp_sd;
			dv_se.den   <= den_sd;
			dv_se.sat_x <= DEN_W'(num_x_sd[NUM_W-1:32]) >= den_sd;
			dv_se.sat_y <= DEN_W'(num_y_sd[NUM_W-1:32]) >= den_sd;
			dv_se.rem_x <= DEN_W'(num_x_sd[NUM_W-1:32]);
			dv_se.rem_y <= DEN_W'(num_y_sd[NUM_W-1:32]);
			dv_se.lo_x  <= num_x_sd[31:0];
			dv_se.lo_y  <= num_y_sd[31:0];
			dv_se.q_x   <= '0;
			dv_se.q_y   <= '0;
		end
	end

	// Divider pipeline: each stage settles one quotient bit of both components.
	dv_t  dv_s [DV_N];
	logic dv_v [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		dv_t din, dout;
		logic vin;
		logic [DEN_W:0] cur_x, cur_y;
		logic ge_x, ge_y;

		if (j == 0) begin : g_first
			assign din = dv_se;
			assign vin = v_se;
		end else begin : g_next
			assign din = dv_s[j-1];
			assign vin = dv_v[j-1];
		end

		always_comb begin
			cur_x = {din.rem_x, din.lo_x[31]};
			cur_y = {din.rem_y, din.lo_y[31]};
			ge_x  = cur_x >= {1'b0, din.den};
			ge_y  = cur_y >= {1'b0, din.den};
			dout       = din;
			dout.rem_x = ge_x ? DEN_W'(cur_x - {1'b0, din.den}) : cur_x[DEN_W-1:0];
			dout.rem_y = ge_y ? DEN_W'(cur_y - {1'b0, din.den}) : cur_y[DEN_W-1:0];
			dout.lo_x  = {din.lo_x[30:0], 1'b0};
			dout.lo_y  = {din.lo_y[30:0], 1'b0};
			dout.q_x   = {din.q_x[30:0], ge_x};
			dout.q_y   = {din.q_y[30:0], ge_y};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (en) begin
				dv_v[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= dout;
			end
		end
	end

	// Output stage: saturate, apply the sign and zero out coincident bodies.
	dv_t dv_last;
	logic [31:0] lim_x, lim_y, mag_x, mag_y;
	logic [31:0] force_x_q, force_y_q;
	logic clamp_q, out_valid_q;

	assign dv_last = dv_s[DV_N-1];

	always_comb begin
		lim_x = dv_last.neg_x ? LIM_NEG : LIM_POS;
		lim_y = dv_last.neg_y ? LIM_NEG : LIM_POS;
		mag_x = (dv_last.sat_x || (dv_last.q_x > lim_x)) ? lim_x : dv_last.q_x;
		mag_y = (dv_last.sat_y || (dv_last.q_y > lim_y)) ? lim_y : dv_last.q_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_x_q <= dv_last.zero ? 32'd0 : (dv_last.neg_x ? 32'(-mag_x) : mag_x);
			force_y_q <= dv_last.zero ? 32'd0 : (dv_last.neg_y ? 32'(-mag_y) : mag_y);
			clamp_q   <= dv_last.clamp;
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_sa        <= 1'b0;
			v_sb        <= 1'b0;
			v_sc        <= 1'b0;
			v_sd        <= 1'b0;
			v_se        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_sa        <= sq_v[SQ_N-1];
			v_sb        <= v_sa;
			v_sc        <= v_sb;
			v_sd        <= v_sc;
			v_se        <= v_sd;
			out_valid_q <= dv_v[DV_N-1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {force_y_q, force_x_q};
	assign m_tuser  = clamp_q;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the pairwise gravity force pipeline.
`timescale 1ns / 100ps

module tb;
	import pgf_pkg::*;

	// One expected result: force on the first body and the clamp flag.
	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic        clamp;
	} force_t;

	// Scoreboard: predicts the force for each accepted pair and checks results in order.
	class force_scoreboard;
		logic [31:0] grav;
		force_t      pending[$];
		int          mismatches;

		function new();
			grav = GRAV_RESET;
			mismatches = 0;
		endfunction

		// Floor square root of a value of up to 128 bits.
		function logic [63:0] isqrt(input logic [127:0] n);
			logic [63:0]  res;
			logic [63:0]  c;
			logic [127:0] cc;
			res = '0;
			for (int b = 63; b >= 0; b--) begin
				c = res | (64'd1 << b);
				cc = {64'd0, c} * {64'd0, c};
				if (cc <= n) res = c;
			end
			return res;
		endfunction

		// Signed, saturated force component from the numerator base and denominator.
		function logic [31:0] axis_force(input logic signed [33:0] d, input logic [255:0] base,
				input logic [255:0] den);
			logic        neg;
			logic [33:0] mag;
			logic [255:0] q;
			logic [31:0] lim;
			neg = d < 0;
			mag = neg ? -d : d;
			q = (base * {222'd0, mag}) / den;
			lim = neg ? LIM_NEG : LIM_POS;
			if (q > {224'd0, lim}) q = {224'd0, lim};
			return neg ? 32'(-q[31:0]) : q[31:0];
		endfunction

		// Expected result for one body pair under the current constant.
		function force_t gravity_force(input logic [255:0] d);
			logic signed [33:0] dx, dy;
			logic [33:0]  ux, uy, thr, r;
			logic [31:0]  ra, rb;
			logic [127:0] d2;
			logic [63:0]  rf;
			logic [255:0] base, den, rc;
			force_t       f;
			dx = 34'(signed'(d[95:64])) - 34'(signed'(d[31:0]));
			dy = 34'(signed'(d[127:96])) - 34'(signed'(d[63:32]));
			ux = dx < 0 ? -dx : dx;
			uy = dy < 0 ? -dy : dy;
			ra = d[223:192];
			rb = d[255:224];
			thr = 34'd3 * 34'(ra > rb ? ra : rb);
			d2 = ({94'd0, ux} * {94'd0, ux} + {94'd0, uy} * {94'd0, uy}) << 32;
			rf = isqrt(d2);
			r = 34'(rf >> 16);
			f.clamp = r < thr;
			rc = {222'd0, f.clamp ? thr : r};
			if (rf == 0) begin
				f.fx = '0;
				f.fy = '0;
			end else begin
				base = {224'd0, grav} * {224'd0, d[159:128]} * {224'd0, d[191:160]};
				den = rc * rc * {192'd0, rf};
				f.fx = axis_force(dx, base, den);
				f.fy = axis_force(dy, base, den);
			end
			return f;
		endfunction

		function void note_pair(input logic [255:0] d);
			pending.push_back(gravity_force(d));
		endfunction

		function void check_force(input logic [63:0] data, input logic [0:0] user);
			force_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: fx=%h fy=%h clamp=%b", data[31:0], data[63:32], user);
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.fx || data[63:32] !== e.fy || user[0] !== e.clamp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected fx=%h fy=%h clamp=%b, got fx=%h fy=%h clamp=%b",
						e.fx, e.fy, e.clamp, data[31:0], data[63:32], user);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;

	force_scoreboard sb;
	int          tx_idle;
	int          rx_idle;
	int          hold_cnt;
	longint      cycles;

	pairwise_gravity_force dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Long receiver hold-off counts down here.
	always @(posedge clk) begin
		if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	// Receiver: random back-pressure, forced low during a hold-off.
	always @(posedge clk) begin
		m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle);
	end

	// Check every result transaction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_force(m_tdata, m_tuser);
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one pair and wait until it is accepted, then idle at random.
	task automatic send_pair(input logic [255:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pair(d);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			@(posedge clk);
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every result is back, then let the pipeline settle.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_grav(input logic [31:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.grav = g;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [255:0] pack_pair(input logic [31:0] ax, ay, bx, by, ma, mb,
			ra, rb);
		return {rb, ra, mb, ma, by, bx, ay, ax};
	endfunction

	// Random pair: mostly nearby bodies with moderate masses, some fully random.
	function automatic logic [255:0] random_pair();
		logic [31:0] ax, ay, ma, mb, ra, rb;
		int          sh;
		if ($urandom_range(0, 9) < 2)
			return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
		ax = $urandom;
		ay = $urandom;
		sh = $urandom_range(4, 31);
		ma = $urandom >> $urandom_range(0, 31);
		mb = $urandom >> $urandom_range(0, 31);
		ra = ($urandom_range(0, 4) == 0) ? 32'd0 : ($urandom >> $urandom_range(8, 31));
		rb = ($urandom_range(0, 4) == 0) ? 32'd0 : ($urandom >> $urandom_range(8, 31));
		return pack_pair(ax, ay, ax + 32'(signed'($urandom) >>> sh),
			ay + 32'(signed'($urandom) >>> sh), ma, mb, ra, rb);
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) send_pair(random_pair());
		stop_sending();
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXU = 32'hFFFF_FFFF;
	localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
	localparam logic [31:0] MINP = 32'h8000_0000;

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		hold_cnt = 0;
		cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs under the reset constant.
		send_pair(pack_pair(0, 0, 0, 0, ONE, ONE, 0, 0));
		send_pair(pack_pair(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0));
		send_pair(pack_pair(0, 0, ONE, 0, ONE, ONE, 0, 0));
		send_pair(pack_pair(0, 0, 0, -ONE, ONE, ONE, 0, 0));
		send_pair(pack_pair(MINP, MINP, MAXP, MAXP, MAXU, MAXU, 0, 0));
		send_pair(pack_pair(MAXP, MAXP, MINP, MINP, MAXU, MAXU, 0, 0));
		send_pair(pack_pair(0, 0, 1, 1, MAXU, MAXU, 0, 0));
		send_pair(pack_pair(0, 0, -1, 0, MAXU, MAXU, 0, 0));
		send_pair(pack_pair(0, 0, ONE, ONE, MAXU, MAXU, MAXU, MAXU));
		send_pair(pack_pair(0, 0, ONE, ONE, MAXU, MAXU, 0, MAXU));
		send_pair(pack_pair(0, 0, 3 * ONE, 0, ONE, ONE, ONE, 0));
		send_pair(pack_pair(0, 0, 3 * ONE - 1, 0, ONE, ONE, 0, ONE));
		send_pair(pack_pair(5, 7, 5, 7, MAXU, MAXU, MAXU, MAXU));
		send_pair(pack_pair(0, 0, ONE, -ONE, 0, MAXU, 0, 0));
		send_pair(pack_pair(MAXU, MAXU, MAXU, MAXU, 0, 0, 1, 1));
		stop_sending();
		drain();

		// Largest constant, sender idles less than the receiver.
		write_grav(MAXU);
		tx_idle = 31;
		rx_idle = 62;
		random_phase(500);
		drain();

		// Zero constant, then a small one; receiver idles less than the sender.
		write_grav(32'd0);
		tx_idle = 62;
		rx_idle = 31;
		random_phase(100);
		drain();
		write_grav(32'd1);
		random_phase(400);
		drain();

		// Random constant, no idling, with a long receiver hold-off.
		write_grav($urandom);
		tx_idle = 0;
		rx_idle = 0;
		hold_cnt <= 400;
		random_phase(535);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- pairwise_gravity_force.f -----
hw/rtl/pgf_pkg.sv
hw/rtl/pairwise_gravity_force.sv
tb/sv/tb.sv
